/* hdl/pidw_pkg.sv */
package pidw_pkg;

    // Data format and fixed-point scaling.
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int FRAC_BITS = 16;

    // Pi in fixed point, rounded from a Q32 value, and the wrap period.
    localparam logic [63:0] PI_Q32 = 64'd13493037705;
    localparam logic [63:0] PI_FIX = (PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic [63:0] PERIOD = PI_FIX << 1;

    // A whole number of periods added to the error so that the remainder
    // operand is never negative.
    localparam logic [63:0] SPAN        = 64'd1 << DATA_W;
    localparam logic [63:0] WRAP_OFFSET = ((SPAN + PERIOD - 64'd1) / PERIOD) * PERIOD;
    localparam int          WRAP_W      = $clog2(SPAN + PI_FIX + WRAP_OFFSET);
    localparam int          PERIOD_W    = $clog2(PERIOD + 64'd1);
    localparam int          WRAP_STEPS  = WRAP_W - PERIOD_W + 1;
    localparam logic [WRAP_W-1:0] WRAP_BIAS = WRAP_W'(PI_FIX + WRAP_OFFSET);

    // Queue between the front and back ends.
    localparam int QUEUE_DEPTH = 32;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Result queue.
    localparam int OUT_DEPTH = 8;
    localparam int OPTR_W    = $clog2(OUT_DEPTH);
    localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

    // Loop modes.
    localparam logic [1:0] MODE_POSITION = 2'd0;
    localparam logic [1:0] MODE_SPEED    = 2'd1;
    localparam logic [1:0] MODE_ANGLE    = 2'd2;

    // Configuration register indexes.
    localparam int         CFG_INDEX_W        = 3;
    localparam logic [2:0] REG_KP             = 3'd0;
    localparam logic [2:0] REG_KI             = 3'd1;
    localparam logic [2:0] REG_KD             = 3'd2;
    localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd3;
    localparam logic [2:0] REG_OUTPUT_LIMIT   = 3'd4;
    localparam logic [2:0] REG_LOOP_MODE      = 3'd5;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        logic  clear;
        word_t err;
        word_t derr;
    } front_item_t;

    // Gains and limits used by the back end.
    typedef struct packed {
        word_t             kp;
        word_t             ki;
        word_t             kd;
        logic [DATA_W-2:0] integral_limit;
        logic [DATA_W-2:0] output_limit;
    } pidw_gain_t;

    // Saturate a wide signed value to the signed word range.
    function automatic word_t sat_wide(input prod_t v);
        word_t r;
        priority if (&v[PROD_W-1:DATA_W-1] || ~|v[PROD_W-1:DATA_W-1])
            r = v[DATA_W-1:0];
        else if (v[PROD_W-1])
            r = {1'b1, {(DATA_W-1){1'b0}}};
        else
            r = {1'b0, {(DATA_W-1){1'b1}}};
        return r;
    endfunction

endpackage

/* hdl/pidw_front.sv */
module pidw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  pidw_pkg::word_t      setpoint,
    input  pidw_pkg::word_t      feedback,
    input  logic                 clear,
    input  logic [1:0]           loop_mode,
    input  logic                 q_pop,
    output logic                 q_push,
    output pidw_pkg::front_item_t q_item
);
    import pidw_pkg::*;

    logic                    accept;
    logic [QCNT_W-1:0]       credit_reg;
    logic [QCNT_W-1:0]       credit_next;

    logic                    a_valid_reg;
    logic                    a_clear_reg;
    logic signed [DATA_W:0]  a_diff_reg;
    logic [WRAP_W-1:0]       wrap_base;

    logic                    red_valid_reg [WRAP_STEPS+1];
    logic                    red_clear_reg [WRAP_STEPS+1];
    word_t                   red_sat_reg   [WRAP_STEPS+1];
    logic [WRAP_W-1:0]       red_rem_reg   [WRAP_STEPS+1];

    logic                    e_valid_reg;
    logic                    e_clear_reg;
    word_t                   e_err_reg;
    word_t                   wrapped_err;
    word_t                   prev_err_reg;
    logic signed [DATA_W:0]  derr_wide;
    word_t                   derr;
    logic                    deriv_on;

    logic                    f_valid_reg;
    front_item_t             f_item_reg;

    // Credits cover items in this pipeline and items waiting in the queue.
    assign full   = (credit_reg == QCNT_W'(QUEUE_DEPTH));
    assign accept = push && !full;

    always_comb
    begin
        credit_next = credit_reg + QCNT_W'(accept) - QCNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            credit_reg <= '0;
        else
            credit_reg <= credit_next;
    end

    // Capture a transaction and form the exact difference.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        a_clear_reg <= clear;
        a_diff_reg  <= {setpoint[DATA_W-1], setpoint} - {feedback[DATA_W-1], feedback};
    end

    // Saturated error and the biased, non-negative operand for the wrap.
    assign wrap_base = {{(WRAP_W-DATA_W-1){a_diff_reg[DATA_W]}}, a_diff_reg} + WRAP_BIAS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            red_valid_reg[0] <= 1'b0;
        else
            red_valid_reg[0] <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        red_clear_reg[0] <= a_clear_reg;
        red_sat_reg[0]   <= sat_wide(PROD_W'(a_diff_reg));
        red_rem_reg[0]   <= wrap_base;
    end

    // Restoring reduction modulo the period, one shifted period per stage.
    for (genvar j = 1; j <= WRAP_STEPS; j++)
    begin : g_reduce
        localparam logic [WRAP_W-1:0] STEP_SUB = WRAP_W'(PERIOD << (WRAP_STEPS - j));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                red_valid_reg[j] <= 1'b0;
            else
                red_valid_reg[j] <= red_valid_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            red_clear_reg[j] <= red_clear_reg[j-1];
            red_sat_reg[j]   <= red_sat_reg[j-1];
            if (red_rem_reg[j-1] >= STEP_SUB)
                red_rem_reg[j] <= red_rem_reg[j-1] - STEP_SUB;
            else
                red_rem_reg[j] <= red_rem_reg[j-1];
        end
    end

    // Select the wrapped or the saturated error by loop mode.
    assign wrapped_err = word_t'(red_rem_reg[WRAP_STEPS][DATA_W-1:0])
                         - word_t'(PI_FIX[DATA_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_valid_reg <= 1'b0;
        else
            e_valid_reg <= red_valid_reg[WRAP_STEPS];
    end

    always_ff @(posedge clk)
    begin
        e_clear_reg <= red_clear_reg[WRAP_STEPS];
        if (loop_mode == MODE_ANGLE)
            e_err_reg <= wrapped_err;
        else
            e_err_reg <= red_sat_reg[WRAP_STEPS];
    end

    // Error difference against the previous item, in item order; zero unless in speed or angle mode.
    assign deriv_on  = (loop_mode == MODE_SPEED) || (loop_mode == MODE_ANGLE);
    assign derr_wide = {e_err_reg[DATA_W-1], e_err_reg} - {prev_err_reg[DATA_W-1], prev_err_reg};
    assign derr      = deriv_on ? sat_wide(PROD_W'(derr_wide)) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            f_valid_reg  <= 1'b0;
        end
        else
        begin
            f_valid_reg <= e_valid_reg;
            if (e_valid_reg)
                prev_err_reg <= e_clear_reg ? '0 : e_err_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f_item_reg.clear <= e_clear_reg;
        f_item_reg.err   <= e_err_reg;
        f_item_reg.derr  <= derr;
    end

    assign q_push = f_valid_reg;
    assign q_item = f_item_reg;

endmodule

/* hdl/pidw_queue.sv */
module pidw_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  pidw_pkg::front_item_t wr_item,
    input  logic                  rd_en,
    output logic                  empty,
    output pidw_pkg::front_item_t rd_item
);
    import pidw_pkg::*;

    front_item_t       mem [QUEUE_DEPTH];
    logic [QPTR_W:0]   wr_ptr_reg;
    logic [QPTR_W:0]   rd_ptr_reg;

    // The producer holds credits, so a write never meets a full queue.
    assign empty   = (wr_ptr_reg == rd_ptr_reg);
    assign rd_item = mem[rd_ptr_reg[QPTR_W-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + (QPTR_W+1)'(1);
            if (rd_en && !empty)
                rd_ptr_reg <= rd_ptr_reg + (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg[QPTR_W-1:0]] <= wr_item;
    end

endmodule

/* hdl/pidw_back.sv */
module pidw_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pidw_pkg::pidw_gain_t  gains,
    input  logic                  q_empty,
    input  pidw_pkg::front_item_t q_item,
    output logic                  q_pop,
    output logic                  empty,
    input  logic                  pop,
    output pidw_pkg::word_t       drive,
    output logic                  limited
);
    import pidw_pkg::*;

    logic                     out_take;
    logic [OCNT_W-1:0]        ocredit_reg;
    logic [OCNT_W-1:0]        ocredit_next;

    logic                     m_valid_reg;
    logic                     m_clear_reg;
    prod_t                    m_p_reg;
    prod_t                    m_i_reg;
    prod_t                    m_d_reg;

    logic                     s_valid_reg;
    logic                     s_clear_reg;
    word_t                    s_p_reg;
    word_t                    s_i_reg;
    word_t                    s_d_reg;

    logic                     i_valid_reg;
    logic                     i_clear_reg;
    word_t                    i_p_reg;
    word_t                    i_d_reg;
    word_t                    integral_reg;
    word_t                    integral_next;
    logic signed [DATA_W:0]   int_sum;
    logic signed [DATA_W:0]   int_lim;
    logic signed [DATA_W:0]   int_neg;

    logic                     o_valid_reg;
    logic                     o_clear_reg;
    logic signed [DATA_W+1:0] o_sum_reg;
    logic signed [DATA_W+1:0] out_lim;
    logic signed [DATA_W+1:0] out_neg;
    word_t                    clamp_drive;
    logic                     clamp_hit;

    word_t                    res_drive_mem   [OUT_DEPTH];
    logic                     res_limited_mem [OUT_DEPTH];
    logic [OPTR_W:0]          res_wr_ptr_reg;
    logic [OPTR_W:0]          res_rd_ptr_reg;

    // Floor shift by the fraction width, then saturate.
    function automatic word_t fx_scale(input prod_t p);
        prod_t s;
        s = p >>> FRAC_BITS;
        return sat_wide(s);
    endfunction

    // Credits cover items in this pipeline and results not yet taken.
    assign q_pop    = !q_empty && (ocredit_reg != OCNT_W'(OUT_DEPTH));
    assign out_take = pop && !empty;

    always_comb
    begin
        ocredit_next = ocredit_reg + OCNT_W'(q_pop) - OCNT_W'(out_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ocredit_reg <= '0;
        else
            ocredit_reg <= ocredit_next;
    end

    // Gain products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= q_pop;
    end

    always_ff @(posedge clk)
    begin
        m_clear_reg <= q_item.clear;
        m_p_reg     <= prod_t'(gains.kp) * prod_t'(q_item.err);
        m_i_reg     <= prod_t'(gains.ki) * prod_t'(q_item.err);
        m_d_reg     <= prod_t'(gains.kd) * prod_t'(q_item.derr);
    end

    // Scale the products back to the word format.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_valid_reg <= 1'b0;
        else
            s_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s_clear_reg <= m_clear_reg;
        s_p_reg     <= fx_scale(m_p_reg);
        s_i_reg     <= fx_scale(m_i_reg);
        s_d_reg     <= fx_scale(m_d_reg);
    end

    // Integral accumulation with its symmetric clamp; a clear item resets it to zero.
    always_comb
    begin
        int_sum = {integral_reg[DATA_W-1], integral_reg} + {s_i_reg[DATA_W-1], s_i_reg};
        int_lim = {2'b00, gains.integral_limit};
        int_neg = -int_lim;
        priority if (s_clear_reg)
            integral_next = '0;
        else if (int_sum > int_lim)
            integral_next = int_lim[DATA_W-1:0];
        else if (int_sum < int_neg)
            integral_next = int_neg[DATA_W-1:0];
        else
            integral_next = int_sum[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            i_valid_reg  <= 1'b0;
        end
        else
        begin
            i_valid_reg <= s_valid_reg;
            if (s_valid_reg)
                integral_reg <= integral_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_clear_reg <= s_clear_reg;
        i_p_reg     <= s_p_reg;
        i_d_reg     <= s_d_reg;
    end

    // Sum of the three terms.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else
            o_valid_reg <= i_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        o_clear_reg <= i_clear_reg;
        o_sum_reg   <= (DATA_W+2)'(i_p_reg) + (DATA_W+2)'(integral_reg)
                       + (DATA_W+2)'(i_d_reg);
    end

    // Output clamp; a clear item gives zero.
    always_comb
    begin
        out_lim = {3'b000, gains.output_limit};
        out_neg = -out_lim;
        priority if (o_clear_reg)
        begin
            clamp_drive = '0;
            clamp_hit   = 1'b0;
        end
        else if (o_sum_reg > out_lim)
        begin
            clamp_drive = out_lim[DATA_W-1:0];
            clamp_hit   = 1'b1;
        end
        else if (o_sum_reg < out_neg)
        begin
            clamp_drive = out_neg[DATA_W-1:0];
            clamp_hit   = 1'b1;
        end
        else
        begin
            clamp_drive = o_sum_reg[DATA_W-1:0];
            clamp_hit   = 1'b0;
        end
    end

    // Result queue.
    assign empty   = (res_wr_ptr_reg == res_rd_ptr_reg);
    assign drive   = res_drive_mem[res_rd_ptr_reg[OPTR_W-1:0]];
    assign limited = res_limited_mem[res_rd_ptr_reg[OPTR_W-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_ptr_reg <= '0;
            res_rd_ptr_reg <= '0;
        end
        else
        begin
            if (o_valid_reg)
                res_wr_ptr_reg <= res_wr_ptr_reg + (OPTR_W+1)'(1);
            if (out_take)
                res_rd_ptr_reg <= res_rd_ptr_reg + (OPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_valid_reg)
        begin
            res_drive_mem[res_wr_ptr_reg[OPTR_W-1:0]]   <= clamp_drive;
            res_limited_mem[res_wr_ptr_reg[OPTR_W-1:0]] <= clamp_hit;
        end
    end

endmodule

/* hdl/pid_controller_angle_wrap_core.sv */
// PID controller with integral clamp, output clamp and angle wrap, in signed
// Q16.16. The block takes one transaction per clock cycle while full is low
// and returns one result per transaction, in order. The front end forms the
// error and, in its 16 compare-and-subtract stages, wraps it into [-pi, pi)
// one shifted period per stage for angle mode; the back end then applies the
// gain multipliers, scaling, integral update, sum and output clamp. A 32-entry
// queue separates the two ends and an 8-entry queue holds finished results;
// full is raised when the front end and the first queue together hold 32
// transactions. The gains, limits and loop mode are written through the
// configuration channel, which is always ready; write them only while no
// transaction is in flight.
module pid_controller_angle_wrap_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  pidw_pkg::word_t                    setpoint,
    input  pidw_pkg::word_t                    feedback,
    input  logic                               clear,
    output logic                               empty,
    input  logic                               pop,
    output pidw_pkg::word_t                    drive,
    output logic                               limited,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pidw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pidw_pkg::DATA_W-1:0]        cfg_data
);
    import pidw_pkg::*;

    pidw_gain_t  gains_reg;
    logic [1:0]  loop_mode_reg;
    logic        cfg_write;

    logic        q_push;
    logic        q_pop;
    logic        q_empty;
    front_item_t q_wr_item;
    front_item_t q_rd_item;

    // Configuration registers.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg     <= '0;
            loop_mode_reg <= MODE_SPEED;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_KP:             gains_reg.kp             <= cfg_data;
                REG_KI:             gains_reg.ki             <= cfg_data;
                REG_KD:             gains_reg.kd             <= cfg_data;
                REG_INTEGRAL_LIMIT: gains_reg.integral_limit <= cfg_data[DATA_W-2:0];
                REG_OUTPUT_LIMIT:   gains_reg.output_limit   <= cfg_data[DATA_W-2:0];
                REG_LOOP_MODE:      loop_mode_reg            <= cfg_data[1:0];
                default:            ;
            endcase
        end
    end

    // Front end: error forming, wrap and error difference.
    pidw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .setpoint  (setpoint),
        .feedback  (feedback),
        .clear     (clear),
        .loop_mode (loop_mode_reg),
        .q_pop     (q_pop),
        .q_push    (q_push),
        .q_item    (q_wr_item)
    );

    // Queue between the two ends.
    pidw_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (q_wr_item),
        .rd_en   (q_pop),
        .empty   (q_empty),
        .rd_item (q_rd_item)
    );

    // Back end: gain terms, integral, clamps and result queue.
    pidw_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .gains   (gains_reg),
        .q_empty (q_empty),
        .q_item  (q_rd_item),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .drive   (drive),
        .limited (limited)
    );

endmodule
